>>> hdl/complementary_tilt_filter_macros.svh
`ifndef COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define COMPLEMENTARY_TILT_FILTER_MACROS_SVH

// Concurrent checks sampled on clk_i, held off while rst_ni is low.
`define CTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tilt filter check failed");

// Checks whose consequent is due in the cycle after the antecedent.
`define CTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tilt filter check failed");

`endif

>>> hdl/ctf_pkg.sv
package ctf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD_US = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT      = 3'd5;

  // field widths
  localparam int RAW_W  = 16;  // raw sensor samples
  localparam int OFS_W  = 17;  // accelerometer offsets
  localparam int BIAS_W = 20;  // gyro bias, raw counts * 16
  localparam int WGT_W  = 16;  // blend weight
  localparam int PER_W  = 16;  // sample period
  localparam int LIM_W  = 18;  // angle limit
  localparam int ANG_W  = 19;  // angles, deg * 1024

  localparam logic [WGT_W-1:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [PER_W-1:0] SAMPLE_PERIOD_RST = 16'd2500;
  localparam logic [LIM_W-1:0] ANGLE_LIMIT_RST  = 18'd46080;

  // internal datapath widths
  localparam int SMP_W        = 18;  // offset-corrected accelerometer sample
  localparam int RATE_W       = 21;  // 16 * gyro - bias
  localparam int PRESCALE_SH  = 20;
  localparam int CX_W         = 41;  // CORDIC vector components
  localparam int CACC_W       = 26;  // CORDIC angle, deg * 65536
  localparam int ATAN_W       = 22;
  localparam int ATAN_LEN     = 24;
  localparam int STEP_W       = 5;
  localparam int RP_W         = 38;  // rate * period
  localparam int G_W          = 54;  // alpha * rate * period
  localparam int MAG_W        = 53;
  localparam int REM_W        = 22;  // working remainder, below three divisors
  localparam int QUO_W        = 34;
  localparam int QG_W         = QUO_W + 1;
  localparam int B_W          = 39;  // blend numerator over 65536
  localparam int V_W          = 20;  // rounded angle before clamp
  localparam int FRAC_SH      = 16;

  localparam logic [REM_W-1:0] RATE_DIV = 22'd1025000;

  // reciprocal of the rate divisor: floor(2^54 / 1025000)
  localparam int XL_SH    = 20;  // low bits of |g| left out of the product
  localparam int XH_W     = MAG_W - XL_SH;
  localparam int RECIP_SH = 54;
  localparam int QT_SH    = RECIP_SH - XL_SH;
  localparam int RCP_W    = 35;
  localparam int RCP_LO_W = 18;
  localparam int RCP_HI_W = RCP_W - RCP_LO_W;
  localparam int QSUM_W   = XH_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RECIP_SH) / 64'(RATE_DIV));

  // divider sequence, by iteration step
  localparam int DIV_STEPS = 6;
  localparam logic [STEP_W-1:0] DIV_MUL_HI = 5'd0;
  localparam logic [STEP_W-1:0] DIV_MUL_LO = 5'd1;
  localparam logic [STEP_W-1:0] DIV_QUOT   = 5'd2;
  localparam logic [STEP_W-1:0] DIV_REM    = 5'd3;
  localparam logic [STEP_W-1:0] DIV_FIX_A  = 5'd4;
  localparam logic [STEP_W-1:0] DIV_FIX_B  = 5'd5;

  localparam logic signed [CACC_W-1:0] QUARTER_TURN  = 26'sd5898240;
  localparam logic signed [CACC_W-1:0] ROUND_HALF    = 26'sd32;
  localparam logic signed [CACC_W-1:0] HALF_TURN_POS = 26'sd184320;
  localparam logic signed [CACC_W-1:0] HALF_TURN_NEG = -26'sd184320;

  localparam logic signed [B_W-1:0] HALF_UP = 39'sd32768;
  localparam logic signed [B_W-1:0] HALF_DN = 39'sd32767;

  typedef struct packed {
    logic signed [OFS_W-1:0]  accel_y_offset;
    logic signed [OFS_W-1:0]  accel_z_offset;
    logic signed [BIAS_W-1:0] gyro_bias;
    logic [WGT_W-1:0]         blend_weight;
    logic [PER_W-1:0]         sample_period_us;
    logic [LIM_W-1:0]         angle_limit;
  } ctf_cfg_t;

  typedef struct packed {
    logic              load;
    logic              pre;
    logic              mul;
    logic              absg;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              rnd;
    logic              blend;
    logic              commit;
  } ctf_ctl_t;

  // atan(2^-i) in degrees * 65536, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/complementary_tilt_filter.sv
// Complementary tilt filter. Each transaction on the input channel carries a
// command bit, a raw gyro X sample and raw accelerometer Y and Z samples, and
// yields exactly one result: the new tilt angle in signed degrees * 1024 and a
// flag that is set when an update was clamped to +/- angle_limit. Command 0
// blends the previous angle plus the gyro increment (weight blend_weight/65536)
// with the accelerometer tilt atan2(y, z); command 1 loads the accelerometer
// tilt directly. Offsets, bias, weight, period and limit are written through
// the cfg port (index 0..5); other indexes are ignored. The user must write
// them only while the block is idle; the block itself does not enforce it.
// One item is in flight at a time; its result enters the output register,
// after which the next item can be taken while the result waits. In the
// iteration loop the vectoring CORDIC does one rotation per cycle; the gyro
// term is divided by 1025000 alongside it, through a reciprocal product and
// two correction steps.
`include "complementary_tilt_filter_macros.svh"

module complementary_tilt_filter
  import ctf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic signed [RAW_W-1:0] gyro_x_i,
  input  logic signed [RAW_W-1:0] accel_y_i,
  input  logic signed [RAW_W-1:0] accel_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ANG_W-1:0] tilt_angle_o,
  output logic                    clamped_o
);

  ctf_cfg_t cfg;
  ctf_ctl_t ctl;

  ctf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ctf_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  ctf_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cfg_i        (cfg),
    .cmd_i        (cmd_i),
    .gyro_x_i     (gyro_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .tilt_angle_o (tilt_angle_o),
    .clamped_o    (clamped_o)
  );

  // an accepted transaction occupies the block until its result is stored
  `CTF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // the output register is only overwritten once its result has left
  `CTF_ASSERT(a_commit_when_free, ctl.commit |-> (!out_valid_o || out_ready_i))
  // the block leaves idle only on an accepted transaction
  `CTF_ASSERT(a_start_on_accept, $fell(in_ready_o) |-> $past(in_valid_i))

endmodule

>>> hdl/ctf_regs.sv
module ctf_regs
  import ctf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output ctf_cfg_t              cfg_o
);

  ctf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_y_offset   <= '0;
      cfg_q.accel_z_offset   <= '0;
      cfg_q.gyro_bias        <= '0;
      cfg_q.blend_weight     <= BLEND_WEIGHT_RST;
      cfg_q.sample_period_us <= SAMPLE_PERIOD_RST;
      cfg_q.angle_limit      <= ANGLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACCEL_Y_OFFSET:   cfg_q.accel_y_offset   <= cfg_wdata_i[OFS_W-1:0];
        REG_ACCEL_Z_OFFSET:   cfg_q.accel_z_offset   <= cfg_wdata_i[OFS_W-1:0];
        REG_GYRO_BIAS:        cfg_q.gyro_bias        <= cfg_wdata_i[BIAS_W-1:0];
        REG_BLEND_WEIGHT:     cfg_q.blend_weight     <= cfg_wdata_i[WGT_W-1:0];
        REG_SAMPLE_PERIOD_US: cfg_q.sample_period_us <= cfg_wdata_i[PER_W-1:0];
        REG_ANGLE_LIMIT:      cfg_q.angle_limit      <= cfg_wdata_i[LIM_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/ctf_ctrl.sv
module ctf_ctrl
  import ctf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctf_ctl_t ctl_o
);

  localparam int ITER_N = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITER_N - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_MUL,
    S_ABS,
    S_ITER,
    S_RND,
    S_BLEND,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ctl_o        = '0;
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.pre    = (state_q == S_PRE);
    ctl_o.mul    = (state_q == S_MUL);
    ctl_o.absg   = (state_q == S_ABS);
    ctl_o.iter   = (state_q == S_ITER);
    ctl_o.step   = step_q;
    ctl_o.rnd    = (state_q == S_RND);
    ctl_o.blend  = (state_q == S_BLEND);
    ctl_o.commit = (state_q == S_DONE) && out_free;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_PRE;
        end
        S_PRE:   state_q <= S_MUL;
        S_MUL:   state_q <= S_ABS;
        S_ABS:   state_q <= S_ITER;
        S_ITER: begin
          if (step_q == LAST_STEP) begin
            step_q  <= '0;
            state_q <= S_RND;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_RND:   state_q <= S_BLEND;
        S_BLEND: state_q <= S_DONE;
        S_DONE: begin
          // hold until the output register can take the result
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ctf_dp.sv
module ctf_dp
  import ctf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctf_ctl_t                ctl_i,
  input  ctf_cfg_t                cfg_i,
  input  logic                    cmd_i,
  input  logic signed [RAW_W-1:0] gyro_x_i,
  input  logic signed [RAW_W-1:0] accel_y_i,
  input  logic signed [RAW_W-1:0] accel_z_i,
  output logic signed [ANG_W-1:0] tilt_angle_o,
  output logic                    clamped_o
);

  localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic                     mode_q;
  logic signed [SMP_W-1:0]  y_q, z_q, y_d, z_d;
  logic signed [RATE_W-1:0] r_q, r_d;
  logic                     zero_q;
  logic signed [CX_W-1:0]   cx_q, cy_q, cx_d, cy_d, xs, ys, dx, dy;
  logic signed [CACC_W-1:0] cacc_q, cacc_d, atan_w, rnd_sum, rnd_sh;
  logic signed [RP_W-1:0]   rp_q;
  logic signed [G_W+0:0]    g_full;
  logic signed [G_W-1:0]    g_q, g_neg;
  logic [MAG_W-1:0]         mag, mag_q;
  logic                     neg_q;
  logic [RCP_HI_W+XH_W-1:0] ph_q;
  logic [RCP_LO_W+XH_W-1:0] pl_q;
  logic [QSUM_W-1:0]        qsum;
  logic [REM_W-1:0]         rem_q, qd_lo, rem_fix;
  logic [QUO_W-1:0]         quo_q;
  logic                     nz_q;
  logic signed [ANG_W-1:0]  acc_q, acc_d;
  logic signed [QG_W-1:0]   qg_q, qpos, nz_w;
  logic signed [V_W-1:0]    diff;
  logic signed [V_W+WGT_W:0] prod;
  logic signed [B_W-1:0]    b_q, b_d, rsum;
  logic signed [V_W-1:0]    v, lim, nlim;
  logic signed [ANG_W-1:0]  angle_q;
  logic signed [ANG_W-1:0]  tilt_q;
  logic                     clamped_q;
  logic signed [ANG_W-1:0]  upd_angle;
  logic                     upd_flag;

  always_comb begin
    y_d = $signed({{(SMP_W-RAW_W){accel_y_i[RAW_W-1]}}, accel_y_i})
        - $signed({cfg_i.accel_y_offset[OFS_W-1], cfg_i.accel_y_offset});
    z_d = $signed({{(SMP_W-RAW_W){accel_z_i[RAW_W-1]}}, accel_z_i})
        - $signed({cfg_i.accel_z_offset[OFS_W-1], cfg_i.accel_z_offset});
    r_d = $signed({gyro_x_i[RAW_W-1], gyro_x_i, 4'b0000})
        - $signed({cfg_i.gyro_bias[BIAS_W-1], cfg_i.gyro_bias});
  end

  // CORDIC load with pre-rotation into the right half plane, and one rotation
  always_comb begin
    xs = $signed({{(CX_W-SMP_W-PRESCALE_SH){z_q[SMP_W-1]}}, z_q, {PRESCALE_SH{1'b0}}});
    ys = $signed({{(CX_W-SMP_W-PRESCALE_SH){y_q[SMP_W-1]}}, y_q, {PRESCALE_SH{1'b0}}});
    dx = cx_q >>> ctl_i.step;
    dy = cy_q >>> ctl_i.step;
    atan_w = $signed({{(CACC_W-ATAN_W){1'b0}}, atan_lut(ctl_i.step)});
    cx_d = cx_q;
    cy_d = cy_q;
    cacc_d = cacc_q;
    if (ctl_i.pre) begin
      cx_d = xs;
      cy_d = ys;
      cacc_d = '0;
      if (z_q[SMP_W-1]) begin
        if (!y_q[SMP_W-1]) begin
          cx_d = ys;
          cy_d = -xs;
          cacc_d = QUARTER_TURN;
        end else begin
          cx_d = -ys;
          cy_d = xs;
          cacc_d = -QUARTER_TURN;
        end
      end
    end else if (ctl_i.iter && (ctl_i.step <= CORDIC_LAST)) begin
      if (!cy_q[CX_W-1]) begin
        cx_d = cx_q + dy;
        cy_d = cy_q - dx;
        cacc_d = cacc_q + atan_w;
      end else begin
        cx_d = cx_q - dy;
        cy_d = cy_q + dx;
        cacc_d = cacc_q - atan_w;
      end
    end
  end

  // |g| / 1025000: reciprocal product of the upper bits lands at most two
  // below the quotient, so two compare and subtract steps finish it
  always_comb begin
    g_neg   = -g_q;
    mag     = g_q[G_W-1] ? g_neg[MAG_W-1:0] : g_q[MAG_W-1:0];
    qsum    = {ph_q, {RCP_LO_W{1'b0}}} + QSUM_W'(pl_q);
    qd_lo   = quo_q[REM_W-1:0] * RATE_DIV;
    rem_fix = rem_q - RATE_DIV;
  end

  // round the CORDIC angle to deg * 1024 and saturate to half a turn
  always_comb begin
    rnd_sum = cacc_q + ROUND_HALF;
    rnd_sh  = rnd_sum >>> 6;
    if (zero_q) begin
      acc_d = '0;
    end else if (rnd_sh > HALF_TURN_POS) begin
      acc_d = HALF_TURN_POS[ANG_W-1:0];
    end else if (rnd_sh < HALF_TURN_NEG) begin
      acc_d = HALF_TURN_NEG[ANG_W-1:0];
    end else begin
      acc_d = rnd_sh[ANG_W-1:0];
    end
    // floor of the signed gyro term over 1025000
    qpos = $signed({1'b0, quo_q});
    nz_w = $signed({{(QG_W-1){1'b0}}, (rem_q != '0)});
  end

  always_comb begin
    diff = $signed({angle_q[ANG_W-1], angle_q}) - $signed({acc_q[ANG_W-1], acc_q});
    prod = diff * $signed({1'b0, cfg_i.blend_weight});
    b_d  = B_W'(prod) + B_W'($signed({acc_q, {FRAC_SH{1'b0}}})) + B_W'(qg_q);
  end

  // round half away from zero, then clamp
  always_comb begin
    rsum = b_q + (b_q[B_W-1] ? (HALF_DN + B_W'({nz_q})) : HALF_UP);
    v    = rsum[FRAC_SH+V_W-1:FRAC_SH];
    lim  = $signed({{(V_W-LIM_W){1'b0}}, cfg_i.angle_limit});
    nlim = -lim;
    upd_flag = 1'b0;
    if (v > lim) begin
      upd_angle = lim[ANG_W-1:0];
      upd_flag  = 1'b1;
    end else if (v < nlim) begin
      upd_angle = nlim[ANG_W-1:0];
      upd_flag  = 1'b1;
    end else begin
      upd_angle = v[ANG_W-1:0];
    end
  end

  assign g_full = rp_q * $signed({1'b0, cfg_i.blend_weight});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= cmd_i;
      y_q    <= y_d;
      z_q    <= z_d;
      r_q    <= r_d;
    end
    if (ctl_i.pre) begin
      zero_q <= (y_q == '0) && (z_q == '0);
      rp_q   <= r_q * $signed({1'b0, cfg_i.sample_period_us});
    end
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cacc_q <= cacc_d;
    if (ctl_i.mul) begin
      g_q <= g_full[G_W-1:0];
    end
    if (ctl_i.absg) begin
      neg_q <= g_q[G_W-1];
      mag_q <= mag;
    end else if (ctl_i.iter) begin
      case (ctl_i.step)
        DIV_MUL_HI: ph_q  <= mag_q[MAG_W-1:XL_SH] * RECIP[RCP_W-1:RCP_LO_W];
        DIV_MUL_LO: pl_q  <= mag_q[MAG_W-1:XL_SH] * RECIP[RCP_LO_W-1:0];
        DIV_QUOT:   quo_q <= qsum[QSUM_W-1:QT_SH];
        DIV_REM:    rem_q <= mag_q[REM_W-1:0] - qd_lo;
        DIV_FIX_A, DIV_FIX_B: begin
          if (rem_q >= RATE_DIV) begin
            rem_q <= rem_fix;
            quo_q <= quo_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ctl_i.rnd) begin
      acc_q <= acc_d;
      nz_q  <= (rem_q != '0);
      qg_q  <= neg_q ? (-qpos - nz_w) : qpos;
    end
    if (ctl_i.blend) begin
      b_q <= b_d;
    end
    if (ctl_i.commit) begin
      tilt_q    <= mode_q ? acc_q : upd_angle;
      clamped_q <= mode_q ? 1'b0 : upd_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (ctl_i.commit) begin
      angle_q <= mode_q ? acc_q : upd_angle;
    end
  end

  assign tilt_angle_o = tilt_q;
  assign clamped_o    = clamped_q;

endmodule
